### sv/tdb_pkg.sv
package tdb_pkg;

	localparam int SCREEN_WIDTH  = 1024;
	localparam int SCREEN_HEIGHT = 768;
	localparam int MAX_SOURCE    = 4096;

	localparam int SRC_W      = 13;
	localparam int OUTW_W     = 11;
	localparam int OUTH_W     = 10;
	localparam int PLACE_W    = 10;
	localparam int STEP_W     = 12;
	localparam int ORG_W      = 13;
	localparam int IDX_W      = 20;
	localparam int COLOR_W    = 8;
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [STEP_W-1:0] STEP_MAX    = '1;
	localparam logic [WORD_W-1:0] BORDER_WORD = 32'h00af00f0;
	localparam logic [7:0]        ALPHA_BYTE  = 8'h0f;

	// border band limits per edge; the bottom and right bands are one row or column thinner than their figure
	localparam logic [OUTH_W-1:0] BORDER_TOP    = 10'd4;
	localparam logic [OUTH_W:0]   BORDER_BOTTOM = 11'd5;
	localparam logic [OUTW_W-1:0] BORDER_LEFT   = 11'd5;
	localparam logic [OUTW_W:0]   BORDER_RIGHT  = 12'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH     = 3'd0,
		REG_SRC_HEIGHT    = 3'd1,
		REG_OUT_WIDTH     = 3'd2,
		REG_OUT_HEIGHT    = 3'd3,
		REG_PLACE_X       = 3'd4,
		REG_PLACE_Y       = 3'd5,
		REG_CENTER_ENABLE = 3'd6,
		REG_BORDER_ENABLE = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [SRC_W-1:0]   src_width;
		logic [SRC_W-1:0]   src_height;
		logic [OUTW_W-1:0]  out_width;
		logic [OUTH_W-1:0]  out_height;
		logic [PLACE_W-1:0] place_x;
		logic [PLACE_W-1:0] place_y;
		logic               center_enable;
		logic               border_enable;
	} cfg_t;

	typedef struct packed {
		logic [OUTH_W-1:0]  trow;
		logic [OUTW_W-1:0]  tcol;
		logic               border;
		logic               last;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pix_t;

	function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v);
		logic [SRC_W-1:0] r;
		if (v == '0)
			r = SRC_W'(1);
		else if (32'(v) > MAX_SOURCE)
			r = SRC_W'(MAX_SOURCE);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [STEP_W-1:0] make_step(input logic [SRC_W-1:0] q);
		logic [STEP_W-1:0] r;
		if (q == '0)
			r = STEP_W'(1);
		else if (q > SRC_W'(STEP_MAX))
			r = STEP_MAX;
		else
			r = q[STEP_W-1:0];
		return r;
	endfunction

	function automatic logic [ORG_W-1:0] origin(
		input logic [ORG_W-1:0]   screen,
		input logic [OUTW_W-1:0]  size,
		input logic [PLACE_W-1:0] place,
		input logic               center
	);
		logic [ORG_W-1:0] sz;
		logic [ORG_W-1:0] r;
		sz = ORG_W'(size);
		if (!center)
			r = ORG_W'(place);
		else if (sz > screen)
			r = '0;
		else
			r = (screen - sz) >> 1;
		return r;
	endfunction

endpackage

### sv/tdb_divider.sv
module tdb_divider
	import tdb_pkg::*;
#(
	parameter int NUM_W = 13,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			if (fits)
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			else
				rem_q <= trial[DEN_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quot = num_q;

endmodule

### sv/tdb_scan.sv
module tdb_scan
	import tdb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COLOR_W-1:0] red,
	input  logic [COLOR_W-1:0] green,
	input  logic [COLOR_W-1:0] blue,
	input  cfg_t               cfg,
	input  logic               step_busy,
	input  logic [STEP_W-1:0]  col_step_new,
	input  logic [STEP_W-1:0]  row_step_new,
	output logic               pix_valid,
	output pix_t               pix,
	input  logic               pix_take
);

	logic [SRC_W-1:0]  scol_q, srow_q;
	logic [OUTW_W-1:0] tcol_q;
	logic [OUTH_W-1:0] trow_q;
	logic [STEP_W-1:0] cph_q, rph_q;
	logic [STEP_W-1:0] cstep_q, rstep_q;
	logic              valid_s1;
	pix_t              pix_s1;

	logic              acc, fstart, row_pick, pick, row_end, frame_end, border;
	logic [SRC_W-1:0]  w, h;
	logic [STEP_W-1:0] cstep, rstep;
	logic [STEP_W:0]   cph_inc, rph_inc;

	assign in_ready = (!valid_s1 || pix_take) && !step_busy;
	assign acc      = in_valid && in_ready;

	assign w      = clamp_src(cfg.src_width);
	assign h      = clamp_src(cfg.src_height);
	assign fstart = (scol_q == '0) && (srow_q == '0);
	assign cstep  = fstart ? col_step_new : cstep_q;
	assign rstep  = fstart ? row_step_new : rstep_q;

	assign row_pick  = (rph_q == '0) && (trow_q < cfg.out_height);
	assign pick      = row_pick && (cph_q == '0) && (tcol_q < cfg.out_width);
	assign row_end   = ({1'b0, scol_q} + 14'd1) >= {1'b0, w};
	assign frame_end = row_end && (({1'b0, srow_q} + 14'd1) >= {1'b0, h});
	assign cph_inc   = {1'b0, cph_q} + 13'd1;
	assign rph_inc   = {1'b0, rph_q} + 13'd1;

	assign border = cfg.border_enable &&
		((trow_q < BORDER_TOP) ||
		 (({1'b0, trow_q} + BORDER_BOTTOM) > {1'b0, cfg.out_height}) ||
		 (tcol_q < BORDER_LEFT) ||
		 (({1'b0, tcol_q} + BORDER_RIGHT) > {1'b0, cfg.out_width}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scol_q   <= '0;
			srow_q   <= '0;
			tcol_q   <= '0;
			trow_q   <= '0;
			cph_q    <= '0;
			rph_q    <= '0;
			cstep_q  <= STEP_W'(1);
			rstep_q  <= STEP_W'(1);
			valid_s1 <= 1'b0;
		end else begin
			if (!valid_s1 || pix_take)
				valid_s1 <= acc && pick;
			if (acc) begin
				if (fstart) begin
					cstep_q <= col_step_new;
					rstep_q <= row_step_new;
				end
				if (frame_end) begin
					scol_q <= '0;
					srow_q <= '0;
					tcol_q <= '0;
					trow_q <= '0;
					cph_q  <= '0;
					rph_q  <= '0;
				end else if (row_end) begin
					scol_q <= '0;
					cph_q  <= '0;
					tcol_q <= '0;
					if (row_pick)
						trow_q <= trow_q + OUTH_W'(1);
					srow_q <= srow_q + SRC_W'(1);
					rph_q  <= (rph_inc >= {1'b0, rstep}) ? '0 : rph_inc[STEP_W-1:0];
				end else begin
					scol_q <= scol_q + SRC_W'(1);
					if (pick)
						tcol_q <= tcol_q + OUTW_W'(1);
					cph_q  <= (cph_inc >= {1'b0, cstep}) ? '0 : cph_inc[STEP_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (!valid_s1 || pix_take)) begin
			pix_s1.trow   <= trow_q;
			pix_s1.tcol   <= tcol_q;
			pix_s1.border <= border;
			pix_s1.last   <= frame_end;
			pix_s1.red    <= red;
			pix_s1.green  <= green;
			pix_s1.blue   <= blue;
		end
	end

	assign pix_valid = valid_s1;
	assign pix       = pix_s1;

endmodule

### sv/tdb_emit.sv
module tdb_emit
	import tdb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              pix_valid,
	input  pix_t              pix,
	output logic              pix_take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  pixel_index,
	output logic [WORD_W-1:0] pixel_word,
	output logic              frame_done
);

	logic                 valid_q;
	logic [IDX_W-1:0]     index_q;
	logic [WORD_W-1:0]    word_q;
	logic                 done_q;

	logic [ORG_W-1:0]     ox, oy, rsum, csum;
	logic [2*ORG_W-1:0]   prod;
	logic [IDX_W-1:0]     index;
	logic [WORD_W-1:0]    word;

	assign ox = origin(ORG_W'(SCREEN_WIDTH), cfg.out_width, cfg.place_x, cfg.center_enable);
	assign oy = origin(ORG_W'(SCREEN_HEIGHT), {1'b0, cfg.out_height}, cfg.place_y,
		cfg.center_enable);
	assign rsum  = oy + ORG_W'(pix.trow);
	assign csum  = ox + ORG_W'(pix.tcol);
	assign prod  = rsum * ORG_W'(SCREEN_WIDTH);
	assign index = prod[IDX_W-1:0] + IDX_W'(csum);
	assign word  = pix.border ? BORDER_WORD : {ALPHA_BYTE, pix.red, pix.green, pix.blue};

	assign pix_take = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pix_take) begin
			valid_q <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take && pix_valid) begin
			index_q <= index;
			word_q  <= word;
			done_q  <= pix.last;
		end
	end

	assign out_valid   = valid_q;
	assign pixel_index = index_q;
	assign pixel_word  = word_q;
	assign frame_done  = done_q;

endmodule

### sv/thumbnail_decimate_blit_top.sv
// channel   handshake               payload
// in        in_valid / in_ready     red, green, blue
// out       out_valid / out_ready   pixel_index, pixel_word, frame_done
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One source pixel per cycle while in_ready is high; a picked pixel passes the scan register, then the output register.
// Steps come from two restoring dividers; after reset and after every
// register write in_ready stays low while they run.
// Output is a single register; a stall there holds the scan register, then in_ready.
// Reset restores the register defaults and clears all counters.
module thumbnail_decimate_blit_top
	import tdb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COLOR_W-1:0]    red,
	input  logic [COLOR_W-1:0]    green,
	input  logic [COLOR_W-1:0]    blue,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      pixel_index,
	output logic [WORD_W-1:0]     pixel_word,
	output logic                  frame_done,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	logic              start_q;
	logic              cfg_acc;
	logic              col_busy, row_busy, step_busy;
	logic [SRC_W-1:0]  col_quot, row_quot;
	logic [OUTW_W-1:0] col_den;
	logic [OUTH_W-1:0] row_den;
	logic              pix_valid, pix_take;
	pix_t              pix;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width     <= 13'd1024;
			cfg_q.src_height    <= 13'd768;
			cfg_q.out_width     <= 11'd1024;
			cfg_q.out_height    <= 10'd768;
			cfg_q.place_x       <= '0;
			cfg_q.place_y       <= '0;
			cfg_q.center_enable <= 1'b1;
			cfg_q.border_enable <= 1'b0;
			start_q             <= 1'b1;
		end else begin
			start_q <= cfg_acc;
			if (cfg_acc) begin
				unique case (reg_index_t'(cfg_index))
					REG_SRC_WIDTH:     cfg_q.src_width     <= cfg_data[SRC_W-1:0];
					REG_SRC_HEIGHT:    cfg_q.src_height    <= cfg_data[SRC_W-1:0];
					REG_OUT_WIDTH:     cfg_q.out_width     <= cfg_data[OUTW_W-1:0];
					REG_OUT_HEIGHT:    cfg_q.out_height    <= cfg_data[OUTH_W-1:0];
					REG_PLACE_X:       cfg_q.place_x       <= cfg_data[PLACE_W-1:0];
					REG_PLACE_Y:       cfg_q.place_y       <= cfg_data[PLACE_W-1:0];
					REG_CENTER_ENABLE: cfg_q.center_enable <= cfg_data[0];
					REG_BORDER_ENABLE: cfg_q.border_enable <= cfg_data[0];
				endcase
			end
		end
	end

	assign col_den = (cfg_q.out_width == '0) ? OUTW_W'(1) : cfg_q.out_width;
	assign row_den = (cfg_q.out_height == '0) ? OUTH_W'(1) : cfg_q.out_height;

	tdb_divider #(.NUM_W(SRC_W), .DEN_W(OUTW_W)) u_col_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (clamp_src(cfg_q.src_width)),
		.den    (col_den),
		.busy   (col_busy),
		.quot   (col_quot)
	);

	tdb_divider #(.NUM_W(SRC_W), .DEN_W(OUTH_W)) u_row_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (clamp_src(cfg_q.src_height)),
		.den    (row_den),
		.busy   (row_busy),
		.quot   (row_quot)
	);

	assign step_busy = start_q || col_busy || row_busy;

	tdb_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.cfg          (cfg_q),
		.step_busy    (step_busy),
		.col_step_new (make_step(col_quot)),
		.row_step_new (make_step(row_quot)),
		.pix_valid    (pix_valid),
		.pix          (pix),
		.pix_take     (pix_take)
	);

	tdb_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pix_valid   (pix_valid),
		.pix         (pix),
		.pix_take    (pix_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_index (pixel_index),
		.pixel_word  (pixel_word),
		.frame_done  (frame_done)
	);

endmodule

### sv/tdb_checker.sv
module tdb_checker
	import tdb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [IDX_W-1:0]      pixel_index,
	input logic [WORD_W-1:0]     pixel_word,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_index) && $stable(pixel_word))
		else $error("stalled output item changed");

	a_word_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_word[31:24] == ALPHA_BYTE) || (pixel_word == BORDER_WORD))
		else $error("malformed pixel word");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input taken while steps recompute");

	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output item without matching input item");

endmodule

bind thumbnail_decimate_blit_top tdb_checker u_tdb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_index (pixel_index),
	.pixel_word  (pixel_word),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import tdb_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 650;
	localparam int HOLD_CYCLES   = 300;

	typedef struct {
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] word;
		logic              done;
	} blit_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [COLOR_W-1:0]    red       = '0;
	logic [COLOR_W-1:0]    green     = '0;
	logic [COLOR_W-1:0]    blue      = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [IDX_W-1:0]      pixel_index;
	logic [WORD_W-1:0]     pixel_word;
	logic                  frame_done;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	thumbnail_decimate_blit_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_index(pixel_index),
		.pixel_word(pixel_word),
		.frame_done(frame_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow registers and decimation state
	cfg_t              shadow;
	logic [11:0]       src_col, src_row;
	logic [OUTW_W-1:0] tgt_col, tgt_row;
	logic [STEP_W-1:0] col_phase, row_phase, col_step, row_step;

	blit_t pending_blits[$];
	int    mismatches   = 0;
	int    items_sent   = 0;
	int    quiet_cycles = 0;
	int    rx_hold      = 0;
	bit    steady_flow  = 1'b0;

	function automatic int source_span(input logic [SRC_W-1:0] v);
		if (v == '0)
			return 1;
		return (int'(v) > MAX_SOURCE) ? MAX_SOURCE : int'(v);
	endfunction

	function automatic logic [STEP_W-1:0] decimation_step(input logic [SRC_W-1:0] src,
			input int size);
		int s;
		s = source_span(src) / ((size == 0) ? 1 : size);
		if (s < 1)
			s = 1;
		if (s > int'(STEP_MAX))
			s = int'(STEP_MAX);
		return STEP_W'(s);
	endfunction

	function automatic int origin_of(input int screen, input int size, input int place,
			input bit center);
		if (!center)
			return place;
		return (size > screen) ? 0 : (screen - size) / 2;
	endfunction

	task automatic latch_steps();
		col_step = decimation_step(shadow.src_width, int'(shadow.out_width));
		row_step = decimation_step(shadow.src_height, int'(shadow.out_height));
	endtask

	task automatic reset_predictor();
		shadow.src_width     = 13'd1024;
		shadow.src_height    = 13'd768;
		shadow.out_width     = 11'd1024;
		shadow.out_height    = 10'd768;
		shadow.place_x       = '0;
		shadow.place_y       = '0;
		shadow.center_enable = 1'b1;
		shadow.border_enable = 1'b0;
		src_col   = '0;
		src_row   = '0;
		tgt_col   = '0;
		tgt_row   = '0;
		col_phase = '0;
		row_phase = '0;
		latch_steps();
	endtask

	task automatic predict_blit(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int    ox, oy, idx;
		bit    row_pick, pick, row_end, frame_end, edge_px;
		blit_t e;
		if (src_col == '0 && src_row == '0)
			latch_steps();
		row_pick  = (row_phase == '0) && (int'(tgt_row) < int'(shadow.out_height));
		pick      = row_pick && (col_phase == '0) && (int'(tgt_col) < int'(shadow.out_width));
		row_end   = int'(src_col) + 1 >= source_span(shadow.src_width);
		frame_end = row_end && (int'(src_row) + 1 >= source_span(shadow.src_height));
		if (pick) begin
			ox = origin_of(SCREEN_WIDTH, int'(shadow.out_width), int'(shadow.place_x),
				shadow.center_enable);
			oy = origin_of(SCREEN_HEIGHT, int'(shadow.out_height), int'(shadow.place_y),
				shadow.center_enable);
			idx = (oy + int'(tgt_row)) * SCREEN_WIDTH + ox + int'(tgt_col);
			edge_px = int'(tgt_row) < int'(BORDER_TOP)
				|| int'(tgt_row) + int'(BORDER_BOTTOM) > int'(shadow.out_height)
				|| int'(tgt_col) < int'(BORDER_LEFT)
				|| int'(tgt_col) + int'(BORDER_RIGHT) > int'(shadow.out_width);
			e.index = idx[IDX_W-1:0];
			e.word  = (shadow.border_enable && edge_px) ? BORDER_WORD : {ALPHA_BYTE, r, g, b};
			e.done  = frame_end;
			pending_blits.push_back(e);
			tgt_col = tgt_col + 1'b1;
		end
		if (frame_end) begin
			src_col   = '0;
			src_row   = '0;
			tgt_col   = '0;
			tgt_row   = '0;
			col_phase = '0;
			row_phase = '0;
		end else if (row_end) begin
			src_col   = '0;
			col_phase = '0;
			tgt_col   = '0;
			if (row_pick)
				tgt_row = tgt_row + 1'b1;
			src_row   = src_row + 1'b1;
			row_phase = (int'(row_phase) + 1 >= int'(row_step)) ? '0 : row_phase + 1'b1;
		end else begin
			src_col   = src_col + 1'b1;
			col_phase = (int'(col_phase) + 1 >= int'(col_step)) ? '0 : col_phase + 1'b1;
		end
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (!in_ready);
		predict_blit(r, g, b);
		items_sent++;
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic write_reg(input reg_index_t which, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (which)
			REG_SRC_WIDTH:     shadow.src_width     = data;
			REG_SRC_HEIGHT:    shadow.src_height    = data;
			REG_OUT_WIDTH:     shadow.out_width     = data[OUTW_W-1:0];
			REG_OUT_HEIGHT:    shadow.out_height    = data[OUTH_W-1:0];
			REG_PLACE_X:       shadow.place_x       = data[PLACE_W-1:0];
			REG_PLACE_Y:       shadow.place_y       = data[PLACE_W-1:0];
			REG_CENTER_ENABLE: shadow.center_enable = data[0];
			REG_BORDER_ENABLE: shadow.border_enable = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain: an unpicked item gives no result, so wait until every expected result is out, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_blits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'haa, 8'h55, 8'h0f);
		send_pixel(8'h55, 8'haa, 8'hf0);
	endtask

	// written mid-frame; placed at the far corner so the index wraps
	task automatic test_small_frame();
		wait_idle();
		write_reg(REG_SRC_WIDTH, 13'd3);
		write_reg(REG_SRC_HEIGHT, 13'd2);
		write_reg(REG_OUT_WIDTH, 13'd2);
		write_reg(REG_OUT_HEIGHT, 13'd1);
		write_reg(REG_CENTER_ENABLE, 13'd0);
		write_reg(REG_PLACE_X, 13'd1023);
		write_reg(REG_PLACE_Y, 13'd1023);
		send_random(8);
	endtask

	task automatic test_zero_and_oversized();
		wait_idle();
		write_reg(REG_CENTER_ENABLE, 13'd1);
		write_reg(REG_SRC_WIDTH, 13'd0);
		write_reg(REG_SRC_HEIGHT, 13'h1fff);
		write_reg(REG_OUT_WIDTH, 13'd0);
		write_reg(REG_OUT_HEIGHT, 13'd1023);
		send_random(4);
		wait_idle();
		write_reg(REG_OUT_WIDTH, 13'd2047);
		write_reg(REG_BORDER_ENABLE, 13'd1);
		send_random(5);
	endtask

	task automatic test_backpressure();
		wait_idle();
		write_reg(REG_SRC_WIDTH, 13'd8);
		write_reg(REG_SRC_HEIGHT, 13'd6);
		write_reg(REG_OUT_WIDTH, 13'd8);
		write_reg(REG_OUT_HEIGHT, 13'd6);
		write_reg(REG_CENTER_ENABLE, 13'd0);
		write_reg(REG_PLACE_X, 13'd0);
		write_reg(REG_PLACE_Y, 13'd0);
		write_reg(REG_BORDER_ENABLE, 13'd0);
		steady_flow = 1'b1;
		rx_hold     = HOLD_CYCLES;
		send_random(48);
		steady_flow = 1'b0;
		wait_idle();
		send_random(24);
	endtask

	task automatic test_random_frames();
		int                target, limit;
		bit                first;
		logic [SRC_W-1:0]  sv;
		logic [OUTW_W-1:0] ow;
		logic [OUTH_W-1:0] oh;
		target = items_sent + RANDOM_ITEMS;
		first  = 1'b1;
		while (items_sent < target) begin
			wait_idle();
			if (first || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 15))
					0: sv = '0;
					1: sv = 13'd4096;
					2: sv = '1;
					3: sv = 13'($urandom);
					default: sv = 13'($urandom_range(1, 16));
				endcase
				write_reg(REG_SRC_WIDTH, sv);
			end
			if (first || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 15))
					0: sv = '0;
					1: sv = 13'd4096;
					2: sv = '1;
					3: sv = 13'($urandom);
					default: sv = 13'($urandom_range(1, 16));
				endcase
				write_reg(REG_SRC_HEIGHT, sv);
			end
			if (first || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 15))
					0: ow = '0;
					1: ow = 11'd1024;
					2: ow = 11'd1025;
					3: ow = '1;
					default: ow = 11'($urandom_range(1, 16));
				endcase
				write_reg(REG_OUT_WIDTH, {2'($urandom), ow});
			end
			if (first || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 15))
					0: oh = '0;
					1: oh = 10'd768;
					2: oh = 10'd769;
					3: oh = '1;
					default: oh = 10'($urandom_range(1, 16));
				endcase
				write_reg(REG_OUT_HEIGHT, {3'($urandom), oh});
			end
			if (first || $urandom_range(0, 1))
				write_reg(REG_PLACE_X, 13'($urandom));
			if (first || $urandom_range(0, 1))
				write_reg(REG_PLACE_Y, 13'($urandom));
			if (first || $urandom_range(0, 1))
				write_reg(REG_CENTER_ENABLE, 13'($urandom));
			if (first || $urandom_range(0, 1))
				write_reg(REG_BORDER_ENABLE, 13'($urandom));
			first = 1'b0;
			limit = 2 * source_span(shadow.src_width) * source_span(shadow.src_height);
			if (limit > 120)
				limit = 120;
			steady_flow = ($urandom_range(0, 3) == 0);
			send_random($urandom_range(1, limit));
			steady_flow = 1'b0;
		end
	endtask

	initial begin : receiver
		int gap;
		forever begin
			if (rx_hold > 0) begin
				repeat (rx_hold) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
				rx_hold = 0;
			end
			gap = steady_flow ? 0 : $urandom_range(0, 3);
			repeat (gap) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_blit
		blit_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_blits.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected pixel: index %0d word %h done %b",
						pixel_index, pixel_word, frame_done);
				mismatches++;
			end else begin
				e = pending_blits.pop_front();
				if (pixel_index !== e.index || pixel_word !== e.word
						|| frame_done !== e.done) begin
					if (mismatches < 10)
						$display("pixel mismatch: exp index %0d word %h done %b, got %0d %h %b",
							e.index, e.word, e.done, pixel_index, pixel_word, frame_done);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		reset_predictor();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_small_frame();
		test_zero_and_oversized();
		test_backpressure();
		test_random_frames();
		wait_idle();
		if (mismatches == 0 && pending_blits.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
